// ===== hdl/quaternion_to_euler_unit_defines.svh =====
// assertion macros for the quaternion to euler unit
// used by quaternion_to_euler_unit.sv; expects clk and rst_n in scope
`ifndef QUATERNION_TO_EULER_UNIT_DEFINES_SVH
`define QUATERNION_TO_EULER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define Q2E_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("q2e check failed");
`define Q2E_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("q2e check failed");
`else
`define Q2E_ASSERT_IMP(name, ante, cons)
`define Q2E_ASSERT_NEXT(name, ante, cons)
`endif
`endif

// ===== hdl/q2e_pkg.sv =====
// shared constants, types and the arctangent table for the quaternion to euler unit
// no dependencies
`default_nettype none
package q2e_pkg;
    localparam int CORDIC_STEPS = 16;
    localparam int OP_W = 36;
    localparam int CD_W = 46;
    localparam int ANG_W = 35;
    localparam int NORM_STEPS = 6;
    localparam int CORD_LAT = 1 + NORM_STEPS + CORDIC_STEPS;
    localparam int DIV_BITS = 31;
    localparam int SQRT_BITS = 31;
    localparam int PREP_LAT = DIV_BITS + 2 + SQRT_BITS;
    localparam int FRONT_LAT = 3;
    localparam int TOTAL_LAT = FRONT_LAT + PREP_LAT + CORD_LAT + 1;

    localparam logic signed [ANG_W-1:0] PI_Q30 = 35'sd3373259426;
    localparam logic signed [15:0] HALF_PI_Q12 = 16'sd6434;

    typedef enum logic [1:0] {
        POLE_NONE  = 2'd0,
        POLE_NORTH = 2'd1,
        POLE_SOUTH = 2'd2,
        POLE_ZERO  = 2'd3
    } pole_t;

    // atan(2^-i) in q.30 radians
    function automatic logic signed [ANG_W-1:0] atan_entry(input int idx);
        logic signed [ANG_W-1:0] r;
        case (idx)
            0: r = 35'sd843314856;
            1: r = 35'sd497837829;
            2: r = 35'sd263043836;
            3: r = 35'sd133525158;
            4: r = 35'sd67021686;
            5: r = 35'sd33543515;
            6: r = 35'sd16775850;
            7: r = 35'sd8388437;
            8: r = 35'sd4194282;
            9: r = 35'sd2097149;
            10: r = 35'sd1048575;
            11: r = 35'sd524287;
            12: r = 35'sd262143;
            13: r = 35'sd131071;
            14: r = 35'sd65535;
            15: r = 35'sd32767;
            16: r = 35'sd16383;
            17: r = 35'sd8191;
            18: r = 35'sd4095;
            19: r = 35'sd2047;
            20: r = 35'sd1023;
            21: r = 35'sd511;
            22: r = 35'sd255;
            23: r = 35'sd127;
            24: r = 35'sd63;
            25: r = 35'sd31;
            26: r = 35'sd15;
            27: r = 35'sd7;
            28: r = 35'sd3;
            29: r = 35'sd1;
            default: r = '0;
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

// ===== hdl/q2e_cordic.sv =====
// pipelined vectoring cordic: atan2(y, x) in q.30 radians
// depends on q2e_pkg
`default_nettype none
module q2e_cordic (
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [q2e_pkg::OP_W-1:0]   y_in,
    input  logic signed [q2e_pkg::OP_W-1:0]   x_in,
    output logic signed [q2e_pkg::ANG_W-1:0]  angle
);
    import q2e_pkg::*;

    logic signed [CD_W-1:0]  x_reg [CORD_LAT];
    logic signed [CD_W-1:0]  y_reg [CORD_LAT];
    logic signed [ANG_W-1:0] z_reg [CORD_LAT];
    logic                    zero_reg [CORD_LAT];

    logic signed [CD_W-1:0] x_ext;
    logic signed [CD_W-1:0] y_ext;

    // shift right, truncating toward zero
    function automatic logic signed [CD_W-1:0] tshift(input logic signed [CD_W-1:0] v,
                                                     input int s);
        logic [CD_W-1:0] m;
        m = v[CD_W-1] ? CD_W'(-v) : CD_W'(v);
        m = m >> s;
        return v[CD_W-1] ? $signed(-m) : $signed(m);
    endfunction

    assign x_ext = CD_W'(x_in);
    assign y_ext = CD_W'(y_in);

    // left half plane is folded by a half turn
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_reg[0] <= (x_in == 0) && (y_in == 0);
            if (x_in < 0)
            begin
                x_reg[0] <= -x_ext;
                y_reg[0] <= -y_ext;
                z_reg[0] <= (y_in >= 0) ? PI_Q30 : -PI_Q30;
            end
            else
            begin
                x_reg[0] <= x_ext;
                y_reg[0] <= y_ext;
                z_reg[0] <= '0;
            end
        end
    end

    // normalize so the larger magnitude lands in [2^40, 2^41)
    for (genvar k = 0; k < NORM_STEPS; k++)
    begin : g_norm
        localparam int SH = 32 >> k;
        localparam int THR = 41 - SH;
        localparam logic [CD_W-1:0] LIM = CD_W'(1) << THR;
        logic [CD_W-1:0] ax;
        logic [CD_W-1:0] ay;
        logic            fits;
        always_comb
        begin
            ax = x_reg[k][CD_W-1] ? CD_W'(-x_reg[k]) : CD_W'(x_reg[k]);
            ay = y_reg[k][CD_W-1] ? CD_W'(-y_reg[k]) : CD_W'(y_reg[k]);
            fits = (ax < LIM) && (ay < LIM);
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[k+1] <= fits ? (x_reg[k] <<< SH) : x_reg[k];
                y_reg[k+1] <= fits ? (y_reg[k] <<< SH) : y_reg[k];
                z_reg[k+1] <= z_reg[k];
                zero_reg[k+1] <= zero_reg[k];
            end
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_iter
        localparam int IDX = 1 + NORM_STEPS + i;
        logic signed [CD_W-1:0] dx;
        logic signed [CD_W-1:0] dy;
        assign dx = tshift(y_reg[IDX-1], i);
        assign dy = tshift(x_reg[IDX-1], i);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                zero_reg[IDX] <= zero_reg[IDX-1];
                if (y_reg[IDX-1] > 0)
                begin
                    x_reg[IDX] <= x_reg[IDX-1] + dx;
                    y_reg[IDX] <= y_reg[IDX-1] - dy;
                    z_reg[IDX] <= z_reg[IDX-1] + atan_entry(i);
                end
                else
                begin
                    x_reg[IDX] <= x_reg[IDX-1] - dx;
                    y_reg[IDX] <= y_reg[IDX-1] + dy;
                    z_reg[IDX] <= z_reg[IDX-1] - atan_entry(i);
                end
            end
        end
    end

    assign angle = zero_reg[CORD_LAT-1] ? '0 : z_reg[CORD_LAT-1];
endmodule
`default_nettype wire

// ===== hdl/q2e_asin_prep.sv =====
// asin argument: q = |test|*2^31/unit (radix-2 divider), c = isqrt(2^60 - q*q)
// depends on q2e_pkg
`default_nettype none
module q2e_asin_prep (
    input  logic                              clk,
    input  logic                              en,
    input  logic [31:0]                       mag_in,
    input  logic [32:0]                       unit_in,
    output logic [q2e_pkg::DIV_BITS-1:0]      q_out,
    output logic [q2e_pkg::SQRT_BITS-1:0]     root
);
    import q2e_pkg::*;

    localparam logic [DIV_BITS-1:0] Q_ONE = DIV_BITS'(1) << 30;
    localparam logic [60:0] ONE60 = 61'(1) << 60;

    logic [32:0]          rem_reg [DIV_BITS];
    logic [32:0]          dd_reg  [DIV_BITS];
    logic [DIV_BITS-1:0]  dq_reg  [DIV_BITS];

    logic [DIV_BITS-1:0]  qc;
    logic [DIV_BITS-1:0]  qc_reg;
    logic [61:0]          sq_reg;
    logic [DIV_BITS-1:0]  qv_reg;
    logic [60:0]          v0_reg;

    logic [60:0]          sv_reg [SQRT_BITS];
    logic [61:0]          sr_reg [SQRT_BITS];
    logic [DIV_BITS-1:0]  sqq_reg [SQRT_BITS];

    // one quotient bit per stage
    for (genvar j = 0; j < DIV_BITS; j++)
    begin : g_div
        logic [32:0]         r_src;
        logic [32:0]         d_src;
        logic [DIV_BITS-1:0] q_src;
        logic [33:0]         r2;
        logic                ge;
        if (j == 0)
        begin : g_first
            assign r_src = {1'b0, mag_in};
            assign d_src = unit_in;
            assign q_src = '0;
        end
        else
        begin : g_rest
            assign r_src = rem_reg[j-1];
            assign d_src = dd_reg[j-1];
            assign q_src = dq_reg[j-1];
        end
        assign r2 = {r_src, 1'b0};
        assign ge = r2 >= {1'b0, d_src};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j] <= ge ? 33'(r2 - {1'b0, d_src}) : r2[32:0];
                dd_reg[j] <= d_src;
                dq_reg[j] <= {q_src[DIV_BITS-2:0], ge};
            end
        end
    end

    assign qc = (dq_reg[DIV_BITS-1] > Q_ONE) ? Q_ONE : dq_reg[DIV_BITS-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qc_reg <= qc;
            sq_reg <= 62'(qc) * 62'(qc);
            qv_reg <= qc_reg;
            v0_reg <= ONE60 - sq_reg[60:0];
        end
    end

    // one root bit per stage, starting at bit 2^60
    for (genvar k = 0; k < SQRT_BITS; k++)
    begin : g_sqrt
        localparam int B = 2 * (SQRT_BITS - 1 - k);
        localparam logic [61:0] BIT = 62'(1) << B;
        logic [60:0]         v_src;
        logic [61:0]         r_src;
        logic [DIV_BITS-1:0] q_src;
        logic [61:0]         t;
        logic                ge;
        if (k == 0)
        begin : g_first
            assign v_src = v0_reg;
            assign r_src = '0;
            assign q_src = qv_reg;
        end
        else
        begin : g_rest
            assign v_src = sv_reg[k-1];
            assign r_src = sr_reg[k-1];
            assign q_src = sqq_reg[k-1];
        end
        assign t = r_src + BIT;
        assign ge = {1'b0, v_src} >= t;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sv_reg[k] <= ge ? 61'({1'b0, v_src} - t) : v_src;
                sr_reg[k] <= ge ? ((r_src >> 1) + BIT) : (r_src >> 1);
                sqq_reg[k] <= q_src;
            end
        end
    end

    assign q_out = sqq_reg[SQRT_BITS-1];
    assign root = sr_reg[SQRT_BITS-1][SQRT_BITS-1:0];
endmodule
`default_nettype wire

// ===== hdl/quaternion_to_euler_unit.sv =====
// quaternion to euler angles, top level with front stages, delay lines and output stage
// depends on q2e_pkg, q2e_cordic, q2e_asin_prep and the defines header
//
//  channel | signals                                          | beat
//  in      | in_valid, in_ready, quat_w/x/y/z                 | one quaternion
//  out     | out_valid, out_ready, heading/attitude/bank_angle,| one euler triple
//          | pole_case                                        |
//
// the pipeline runs through 3 front stages (products, sums, pole decision), the divider and
// square root, the asin cordic and one output register; heading and bank cordics run early
// and their angles are delayed to line up. one beat per cycle when out is not stalled.
// a stall on out freezes the whole pipeline; rst_n clears only the valid bits.
`default_nettype none
`include "quaternion_to_euler_unit_defines.svh"
module quaternion_to_euler_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] quat_w,
    input  logic signed [15:0] quat_x,
    input  logic signed [15:0] quat_y,
    input  logic signed [15:0] quat_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] heading_angle,
    output logic signed [15:0] attitude_angle,
    output logic signed [15:0] bank_angle,
    output logic [1:0]         pole_case
);
    import q2e_pkg::*;

    logic pipe_en;
    logic [TOTAL_LAT-1:0] vld_reg;

    // stage 1: products
    logic signed [31:0] sqw_reg, sqx_reg, sqy_reg, sqz_reg;
    logic signed [31:0] xy_reg, zw_reg, yw_reg, xz_reg, xw_reg, yz_reg;
    logic signed [15:0] w1_reg, x1_reg;
    // stage 2: sums
    logic [32:0]            unit_reg;
    logic signed [32:0]     test_reg;
    logic signed [OP_W-1:0] hy2_reg, hx2_reg, by2_reg, bx2_reg;
    logic signed [15:0]     w2_reg, x2_reg;
    // stage 3: pole decision
    logic signed [44:0]     test_k;
    logic signed [44:0]     unit_k;
    pole_t                  pole_next;
    pole_t                  pole_reg;
    logic signed [OP_W-1:0] hy_reg, hx_reg, by_reg, bx_reg;
    logic [31:0]            tmag_reg;
    logic [32:0]            unit3_reg;
    logic                   tneg_reg;

    logic signed [ANG_W-1:0] head_z, bank_z, att_z;
    logic [DIV_BITS-1:0]     q_val;
    logic [SQRT_BITS-1:0]    c_val;
    logic signed [OP_W-1:0]  att_y, att_x;

    logic signed [ANG_W-1:0] hz_reg [PREP_LAT];
    logic signed [ANG_W-1:0] bz_reg [PREP_LAT];
    logic                    tn_reg [PREP_LAT];
    pole_t                   pl_reg [PREP_LAT + CORD_LAT];

    logic signed [15:0] head_next, att_next, bank_next;
    logic signed [15:0] head_reg, att_reg, bank_reg;
    pole_t              pole_out_reg;
    pole_t              pole_end;
    logic signed [ANG_W-1:0] hz_end, bz_end;

    // round q.30 (possibly doubled) to q3.12 with saturation
    function automatic logic signed [15:0] to_q12(input logic signed [ANG_W:0] a);
        logic signed [ANG_W+2:0] t;
        t = (($signed((ANG_W+3)'(a))) + (ANG_W+3)'(131072)) >>> 18;
        if (t > 32767)
            return 16'sh7fff;
        else if (t < -32768)
            return 16'sh8000;
        else
            return 16'(t);
    endfunction

    assign out_valid = vld_reg[TOTAL_LAT-1];
    assign pipe_en = out_ready || !out_valid;
    assign in_ready = pipe_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (pipe_en)
            vld_reg <= {vld_reg[TOTAL_LAT-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            sqw_reg <= quat_w * quat_w;
            sqx_reg <= quat_x * quat_x;
            sqy_reg <= quat_y * quat_y;
            sqz_reg <= quat_z * quat_z;
            xy_reg <= quat_x * quat_y;
            zw_reg <= quat_z * quat_w;
            yw_reg <= quat_y * quat_w;
            xz_reg <= quat_x * quat_z;
            xw_reg <= quat_x * quat_w;
            yz_reg <= quat_y * quat_z;
            w1_reg <= quat_w;
            x1_reg <= quat_x;

            unit_reg <= 33'(34'(sqw_reg) + 34'(sqx_reg) + 34'(sqy_reg) + 34'(sqz_reg));
            test_reg <= 33'(xy_reg) + 33'(zw_reg);
            hy2_reg <= (OP_W'(yw_reg) - OP_W'(xz_reg)) <<< 1;
            hx2_reg <= OP_W'(sqx_reg) - OP_W'(sqy_reg) - OP_W'(sqz_reg) + OP_W'(sqw_reg);
            by2_reg <= (OP_W'(xw_reg) - OP_W'(yz_reg)) <<< 1;
            bx2_reg <= OP_W'(sqy_reg) - OP_W'(sqx_reg) - OP_W'(sqz_reg) + OP_W'(sqw_reg);
            w2_reg <= w1_reg;
            x2_reg <= x1_reg;
        end
    end

    // exact pole tests: 1000*test against 499*unit
    always_comb
    begin
        test_k = 45'(test_reg) * 45'sd1000;
        unit_k = $signed({12'b0, unit_reg}) * 45'sd499;
        if (unit_reg == '0)
            pole_next = POLE_ZERO;
        else if (test_k > unit_k)
            pole_next = POLE_NORTH;
        else if (test_k < -unit_k)
            pole_next = POLE_SOUTH;
        else
            pole_next = POLE_NONE;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            pole_reg <= pole_next;
            if (pole_next == POLE_NORTH || pole_next == POLE_SOUTH)
            begin
                hy_reg <= OP_W'(x2_reg);
                hx_reg <= OP_W'(w2_reg);
            end
            else
            begin
                hy_reg <= hy2_reg;
                hx_reg <= hx2_reg;
            end
            by_reg <= by2_reg;
            bx_reg <= bx2_reg;
            tmag_reg <= test_reg[32] ? 32'(-test_reg) : 32'(test_reg);
            unit3_reg <= unit_reg;
            tneg_reg <= test_reg[32];
        end
    end

    q2e_cordic u_head (
        .clk   (clk),
        .en    (pipe_en),
        .y_in  (hy_reg),
        .x_in  (hx_reg),
        .angle (head_z)
    );

    q2e_cordic u_bank (
        .clk   (clk),
        .en    (pipe_en),
        .y_in  (by_reg),
        .x_in  (bx_reg),
        .angle (bank_z)
    );

    q2e_asin_prep u_prep (
        .clk     (clk),
        .en      (pipe_en),
        .mag_in  (tmag_reg),
        .unit_in (unit3_reg),
        .q_out   (q_val),
        .root    (c_val)
    );

    // delay lines that keep sideband in step with the asin path
    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            hz_reg[0] <= head_z;
            bz_reg[0] <= bank_z;
            tn_reg[0] <= tneg_reg;
            for (int i = 1; i < PREP_LAT; i++)
            begin
                hz_reg[i] <= hz_reg[i-1];
                bz_reg[i] <= bz_reg[i-1];
                tn_reg[i] <= tn_reg[i-1];
            end
            pl_reg[0] <= pole_reg;
            for (int i = 1; i < PREP_LAT + CORD_LAT; i++)
                pl_reg[i] <= pl_reg[i-1];
        end
    end

    // asin(s) = atan2(s, sqrt(1 - s*s))
    assign att_y = tn_reg[PREP_LAT-1] ? -$signed(OP_W'(q_val)) : $signed(OP_W'(q_val));
    assign att_x = $signed(OP_W'(c_val));

    q2e_cordic u_att (
        .clk   (clk),
        .en    (pipe_en),
        .y_in  (att_y),
        .x_in  (att_x),
        .angle (att_z)
    );

    assign pole_end = pl_reg[PREP_LAT + CORD_LAT - 1];
    assign hz_end = hz_reg[PREP_LAT-1];
    assign bz_end = bz_reg[PREP_LAT-1];

    always_comb
    begin
        head_next = '0;
        att_next = '0;
        bank_next = '0;
        case (pole_end)
            POLE_NORTH:
            begin
                head_next = to_q12((ANG_W+1)'(hz_end) <<< 1);
                att_next = HALF_PI_Q12;
            end
            POLE_SOUTH:
            begin
                head_next = to_q12(-((ANG_W+1)'(hz_end) <<< 1));
                att_next = -HALF_PI_Q12;
            end
            POLE_NONE:
            begin
                head_next = to_q12((ANG_W+1)'(hz_end));
                att_next = to_q12((ANG_W+1)'(att_z));
                bank_next = to_q12((ANG_W+1)'(bz_end));
            end
            default:
            begin
                head_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            head_reg <= head_next;
            att_reg <= att_next;
            bank_reg <= bank_next;
            pole_out_reg <= pole_end;
        end
    end

    assign heading_angle = head_reg;
    assign attitude_angle = att_reg;
    assign bank_angle = bank_reg;
    assign pole_case = pole_out_reg;

    `Q2E_ASSERT_NEXT(a_stall_freezes_pipe, !pipe_en, $stable(vld_reg))
    `Q2E_ASSERT_IMP(a_zero_gives_zero, out_valid && pole_case == POLE_ZERO, heading_angle == 0 && attitude_angle == 0 && bank_angle == 0)
    `Q2E_ASSERT_IMP(a_north_pole_fixed, out_valid && pole_case == POLE_NORTH, attitude_angle == HALF_PI_Q12 && bank_angle == 0)
    `Q2E_ASSERT_IMP(a_attitude_bounded, out_valid && pole_case == POLE_NONE, attitude_angle <= HALF_PI_Q12 + 16'sd1 && attitude_angle >= -HALF_PI_Q12 - 16'sd1)
endmodule
`default_nettype wire
